[design/ose_pkg.sv]
// Shared types and constants for the odometry scale estimator.
package ose_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    // Configuration register indexes
    localparam logic [1:0] CFG_CV_THR    = 2'd0;
    localparam logic [1:0] CFG_MIN_STEP  = 2'd1;
    localparam logic [1:0] CFG_MAX_STEP  = 2'd2;
    localparam logic [1:0] CFG_MIN_COUNT = 2'd3;

    localparam logic [16:0] CV_THR_RST    = 17'd4587;
    localparam logic [30:0] MIN_STEP_RST  = 31'd1966;
    localparam logic [30:0] MAX_STEP_RST  = 31'd6554;
    localparam logic [15:0] MIN_COUNT_RST = 16'd10;

    // Result status codes
    localparam logic [2:0] ST_FIRST  = 3'd0;
    localparam logic [2:0] ST_ACCEPT = 3'd1;
    localparam logic [2:0] ST_SMALL  = 3'd2;
    localparam logic [2:0] ST_REBASE = 3'd3;
    localparam logic [2:0] ST_FIXED  = 3'd4;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

endpackage

[design/ose_in_if.sv]
// Input channel: one odometry/marker position pair per item.
interface ose_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] odom_x;
    logic signed [31:0] odom_y;
    logic signed [31:0] odom_z;
    logic signed [31:0] marker_x;
    logic signed [31:0] marker_y;
    logic signed [31:0] marker_z;

    modport source (output valid, odom_x, odom_y, odom_z, marker_x, marker_y, marker_z,
                    input ready);
    modport sink   (input valid, odom_x, odom_y, odom_z, marker_x, marker_y, marker_z,
                    output ready);
endinterface

[design/ose_out_if.sv]
// Output channel: one estimator result per item.
interface ose_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] avg_scale;
    logic [31:0] variation_coef;
    logic [15:0] sample_count;
    logic        scale_fixed;
    logic [2:0]  status;

    modport source (output valid, avg_scale, variation_coef, sample_count, scale_fixed,
                    status, input ready);
    modport sink   (input valid, avg_scale, variation_coef, sample_count, scale_fixed,
                    status, output ready);
endinterface

[design/odometry_scale_estimator.sv]
// Odometry scale estimator top level: sequencer around a shared divide/root unit.
//
// Takes one item at a time; i_item.ready is high only while the block is idle.
// The first item after reset, and any item once the scale is fixed, returns a
// result in the cycle after acceptance. Any other item measures two step lengths
// with a shared 32x32 multiplier (six squares) and a shared shift-subtract unit
// (one square root per length); a rejected step ends there. An accepted step
// adds a ratio divide, two running-update divides, the variance product, a root
// and a final divide (the root and the final divide are skipped when the new mean
// is zero). The result then waits in output registers until o_result.ready.
// Configuration writes take effect at once and are meant for idle periods.
module odometry_scale_estimator
    import ose_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ose_in_if.sink      i_item,
    ose_out_if.source   o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    localparam int DW = 36;   // remainder width of the shared unit
    localparam int CW = 33;   // width used for count compares

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ADD, S_LEN_O, S_LEN_M, S_RATIO, S_MEAN,
        S_VMUL, S_VSUB, S_VAR, S_DEV, S_COEF, S_FIX, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [16:0] r_cv_thr;
    logic [30:0] r_min_step;
    logic [30:0] r_max_step;
    logic [15:0] r_min_cnt;

    // estimator state
    logic                  r_first;
    logic                  r_fixed;
    logic signed [31:0]    r_ref [6];
    logic signed [31:0]    r_in  [6];
    logic [COUNT_BITS-1:0] r_count;
    logic [31:0]           r_mean;
    logic [31:0]           r_var;
    logic [31:0]           r_coef;
    logic [2:0]            r_status;

    // working registers
    logic [2:0]  r_k;
    logic [65:0] r_sum;
    logic        r_sat;
    logic [63:0] r_prod;
    logic [31:0] r_olen;
    logic [31:0] r_s;
    logic [31:0] r_d1;
    logic [31:0] r_d2;
    logic        r_dneg;

    // shared shift-subtract unit
    logic [63:0]   r_x;
    logic [63:0]   r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic          r_sqrt;
    logic [6:0]    r_cnt;

    logic [DW-1:0] u_shift;
    logic [DW-1:0] u_trial;
    logic [DW-1:0] u_diff;
    logic          u_ge;
    logic          u_done;

    // combinational helpers
    logic signed [32:0] diff_k;
    logic [31:0]        mag_k;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [65:0]        sum_n;
    logic [31:0]        mlen_w;
    logic [31:0]        quo32;
    logic [32:0]        d_mean;
    logic [31:0]        nm_w;
    logic [32:0]        d_nm;
    logic [63:0]        t_sh;
    logic [31:0]        t_w;
    logic [32:0]        d_var;
    logic [31:0]        nv_w;
    logic [COUNT_BITS:0] n1;
    logic [CW-1:0]      cnt_ext;
    logic               accept;

    assign accept = i_item.valid && i_item.ready;

    always_comb begin
        if (r_sqrt) begin
            u_shift = {r_rem[DW-3:0], r_x[63:62]};
            u_trial = {{(DW-34){1'b0}}, r_q[31:0], 2'b01};
        end else begin
            u_shift = {r_rem[DW-2:0], r_x[63]};
            u_trial = r_dvs;
        end
        u_ge   = (u_shift >= u_trial);
        u_diff = u_shift - u_trial;
    end

    assign u_done = (r_cnt == 7'd0);

    always_comb begin
        diff_k = {r_in[r_k][31], r_in[r_k]} - {r_ref[r_k][31], r_ref[r_k]};
        mag_k  = diff_k[32] ? 32'(-diff_k) : diff_k[31:0];
    end

    assign mul_a = (r_state == S_VMUL) ? r_d1 : mag_k;
    assign mul_b = (r_state == S_VMUL) ? r_d2 : mag_k;

    assign sum_n  = r_sum + {2'b00, r_prod};
    assign mlen_w = r_sat ? SAT32 : r_q[31:0];
    assign quo32  = (r_q[63:32] != 32'd0) ? SAT32 : r_q[31:0];

    // mean update pieces
    assign d_mean = {1'b0, quo32} - {1'b0, r_mean};
    assign nm_w   = r_dneg ? (r_mean - r_q[31:0]) : (r_mean + r_q[31:0]);
    assign d_nm   = {1'b0, r_s} - {1'b0, nm_w};

    // variance update pieces
    assign t_sh  = r_prod >> FRAC_BITS;
    assign t_w   = (t_sh[63:32] != 32'd0) ? SAT32 : t_sh[31:0];
    assign d_var = {1'b0, t_w} - {1'b0, r_var};
    assign nv_w  = r_dneg ? (r_var - r_q[31:0]) : (r_var + r_q[31:0]);

    assign n1      = {1'b0, r_count} + (COUNT_BITS+1)'(1);
    assign cnt_ext = CW'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cv_thr   <= CV_THR_RST;
            r_min_step <= MIN_STEP_RST;
            r_max_step <= MAX_STEP_RST;
            r_min_cnt  <= MIN_COUNT_RST;
            r_first    <= 1'b1;
            r_fixed    <= 1'b0;
            r_count    <= '0;
            r_mean     <= '0;
            r_var      <= '0;
            r_coef     <= SAT32;
            r_status   <= ST_FIRST;
            r_cnt      <= '0;
            r_sqrt     <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_ref[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CV_THR:    r_cv_thr   <= i_cfg_data[16:0];
                    CFG_MIN_STEP:  r_min_step <= i_cfg_data;
                    CFG_MAX_STEP:  r_max_step <= i_cfg_data;
                    CFG_MIN_COUNT: r_min_cnt  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // advance the shared unit one step
            if (!u_done) begin
                r_rem <= u_ge ? u_diff : u_shift;
                r_x   <= r_sqrt ? (r_x << 2) : (r_x << 1);
                r_q   <= {r_q[62:0], u_ge};
                r_cnt <= r_cnt - 7'd1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_in[0] <= i_item.odom_x;
                        r_in[1] <= i_item.odom_y;
                        r_in[2] <= i_item.odom_z;
                        r_in[3] <= i_item.marker_x;
                        r_in[4] <= i_item.marker_y;
                        r_in[5] <= i_item.marker_z;
                        if (r_fixed) begin
                            r_status <= ST_FIXED;
                            r_state  <= S_OUT;
                        end else if (r_first) begin
                            r_ref[0] <= i_item.odom_x;
                            r_ref[1] <= i_item.odom_y;
                            r_ref[2] <= i_item.odom_z;
                            r_ref[3] <= i_item.marker_x;
                            r_ref[4] <= i_item.marker_y;
                            r_ref[5] <= i_item.marker_z;
                            r_first  <= 1'b0;
                            r_status <= ST_FIRST;
                            r_state  <= S_OUT;
                        end else begin
                            r_k     <= 3'd0;
                            r_sum   <= '0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (r_k == 3'd2 || r_k == 3'd5) begin
                        // start the root of the sum of squares
                        r_sat  <= |sum_n[65:64];
                        r_sum  <= '0;
                        r_x    <= sum_n[63:0];
                        r_q    <= '0;
                        r_rem  <= '0;
                        r_sqrt <= 1'b1;
                        r_cnt  <= 7'd32;
                        r_k    <= r_k + 3'd1;
                        r_state <= (r_k == 3'd2) ? S_LEN_O : S_LEN_M;
                    end else begin
                        r_sum   <= sum_n;
                        r_k     <= r_k + 3'd1;
                        r_state <= S_MUL;
                    end
                end
                S_LEN_O: begin
                    if (u_done) begin
                        r_olen  <= mlen_w;
                        r_state <= S_MUL;
                    end
                end
                S_LEN_M: begin
                    if (u_done) begin
                        if (mlen_w < {1'b0, r_max_step} && mlen_w > {1'b0, r_min_step}) begin
                            r_x     <= {32'd0, r_olen} << FRAC_BITS;
                            r_q     <= '0;
                            r_rem   <= '0;
                            r_dvs   <= DW'(mlen_w);
                            r_sqrt  <= 1'b0;
                            r_cnt   <= 7'd64;
                            r_state <= S_RATIO;
                        end else if (mlen_w > {1'b0, r_max_step}) begin
                            r_ref    <= r_in;
                            r_status <= ST_REBASE;
                            r_state  <= S_OUT;
                        end else begin
                            r_status <= ST_SMALL;
                            r_state  <= S_OUT;
                        end
                    end
                end
                S_RATIO: begin
                    if (u_done) begin
                        // divide |s - mean| by n+1
                        r_s     <= quo32;
                        r_dneg  <= d_mean[32];
                        r_d1    <= d_mean[32] ? 32'(-d_mean) : d_mean[31:0];
                        r_x     <= {32'd0, (d_mean[32] ? 32'(-d_mean) : d_mean[31:0])};
                        r_q     <= '0;
                        r_rem   <= '0;
                        r_dvs   <= DW'(n1);
                        r_cnt   <= 7'd64;
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (u_done) begin
                        r_mean  <= nm_w;
                        r_d2    <= d_nm[32] ? 32'(-d_nm) : d_nm[31:0];
                        r_state <= S_VMUL;
                    end
                end
                S_VMUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_VSUB;
                end
                S_VSUB: begin
                    r_dneg  <= d_var[32];
                    r_x     <= {32'd0, (d_var[32] ? 32'(-d_var) : d_var[31:0])};
                    r_q     <= '0;
                    r_rem   <= '0;
                    r_dvs   <= DW'(n1);
                    r_cnt   <= 7'd64;
                    r_state <= S_VAR;
                end
                S_VAR: begin
                    if (u_done) begin
                        r_var <= nv_w;
                        if (r_count != {COUNT_BITS{1'b1}}) begin
                            r_count <= r_count + COUNT_BITS'(1);
                        end
                        if (r_mean == 32'd0) begin
                            r_coef  <= SAT32;
                            r_state <= S_FIX;
                        end else begin
                            r_x     <= {32'd0, nv_w} << FRAC_BITS;
                            r_q     <= '0;
                            r_rem   <= '0;
                            r_sqrt  <= 1'b1;
                            r_cnt   <= 7'd32;
                            r_state <= S_DEV;
                        end
                    end
                end
                S_DEV: begin
                    if (u_done) begin
                        r_x     <= {32'd0, r_q[31:0]} << FRAC_BITS;
                        r_q     <= '0;
                        r_rem   <= '0;
                        r_dvs   <= DW'(r_mean);
                        r_sqrt  <= 1'b0;
                        r_cnt   <= 7'd64;
                        r_state <= S_COEF;
                    end
                end
                S_COEF: begin
                    if (u_done) begin
                        r_coef  <= quo32;
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    if (r_coef < {15'd0, r_cv_thr} && cnt_ext > CW'(r_min_cnt)) begin
                        r_fixed <= 1'b1;
                    end
                    r_ref    <= r_in;
                    r_status <= ST_ACCEPT;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (o_result.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_item.ready            = (r_state == S_IDLE);
    assign o_result.valid          = (r_state == S_OUT);
    assign o_result.avg_scale      = r_mean;
    assign o_result.variation_coef = r_coef;
    assign o_result.sample_count   = (cnt_ext > CW'(16'hFFFF)) ? 16'hFFFF : cnt_ext[15:0];
    assign o_result.scale_fixed    = r_fixed;
    assign o_result.status         = r_status;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_item.ready && o_result.valid))
        else $error("input ready while a result is pending");

    a_fixed_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fixed |=> r_fixed)
        else $error("fixed flag dropped");

    a_fixed_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_fixed) |=> (o_result.valid && o_result.status == ST_FIXED))
        else $error("item after fixing not answered with fixed status");

    a_first_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status == ST_FIRST) |-> (o_result.sample_count == 16'd0))
        else $error("first item reported with nonzero count");
`endif

endmodule
